// ===== rtl/itc_pkg.sv =====
`timescale 1ns / 1ps

package itc_pkg;

    // Item codes
    typedef enum logic [1:0] {
        FUNC_TICK = 2'd0,
        FUNC_ON   = 2'd1,
        FUNC_OFF  = 2'd2,
        FUNC_ADD  = 2'd3
    } t_func;

    // Configuration register indexes
    localparam logic [2:0] CFG_RUN_SECONDS   = 3'd0;
    localparam logic [2:0] CFG_START_MINUTES = 3'd1;
    localparam logic [2:0] CFG_START_COUNT   = 3'd2;
    localparam logic [2:0] CFG_DAY_MASK      = 3'd3;
    localparam logic [2:0] CFG_DRY_LEVEL     = 3'd4;
    localparam logic [2:0] CFG_WET_LEVEL     = 3'd5;
    localparam logic [2:0] CFG_DRY_THRESHOLD = 3'd6;
    localparam logic [2:0] CFG_CONTROL_FLAGS = 3'd7;

    // Control flag bit positions
    localparam int FLAG_ACTIVE   = 0;
    localparam int FLAG_OVERRIDE = 1;
    localparam int FLAG_SENSE    = 2;

    localparam int SLOT_W   = 11;
    localparam int CFG_W    = 44;
    localparam int ALU_W    = 35;
    localparam int REM_W    = 23;

    localparam logic [16:0] MAX_LEFT    = 17'h1FFFF;
    localparam logic [10:0] SEC_PER_MIN = 11'd60;
    localparam logic [6:0]  PCT_FULL    = 7'd100;
    localparam logic [31:0] START_GAP   = 32'd60;

    typedef struct packed {
        t_func       func;
        logic [31:0] now_seconds;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [2:0]  weekday;
        logic [15:0] moisture_sample;
        logic [15:0] extra_seconds;
    } t_in_word;

    typedef struct packed {
        logic        relay_on;
        logic        switched;
        logic [16:0] seconds_left;
        logic        soil_dry;
        logic [6:0]  moisture_percent;
    } t_out_word;

    typedef struct packed {
        logic [ALU_W-1:0] diff;
        logic             neg;
        logic             zero;
    } t_sub_res;

endpackage

// ===== rtl/irrigation_timer_controller_unit.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Word
// input     in         i_in_valid / o_in_ready     i_in_word  (t_in_word)
// result    out        o_out_valid / i_out_ready   o_out_word (t_out_word)
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A tick with sensing on runs prepare, elapsed time, seconds left, seven divider steps, measure,
// decide and load. Repeated seconds and manual on/off go from prepare to load; add run time
// runs elapsed time and seconds left; sensing off skips divider and measure, dry not above wet
// skips the divider. Synchronous active-low reset clears control state, loads register defaults.
// The next word is taken while a result waits; a finished item stalls in its load step
// while the output register is still full. Configuration is taken only while idle.

module irrigation_timer_controller_unit
    import itc_pkg::*;
#(
    parameter int START_SLOTS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_word         i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_word        o_out_word,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [2:0]       i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data
);

    localparam int          SLOTS_BITS = START_SLOTS * SLOT_W;
    localparam logic [2:0]  SLOTS_MAX  = 3'(START_SLOTS);
    localparam logic [2:0]  DIV_TOP    = 3'd6;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_PREP   = 8'b0000_0010,
        S_ELAP   = 8'b0000_0100,
        S_LEFT   = 8'b0000_1000,
        S_DIV    = 8'b0001_0000,
        S_MEAS   = 8'b0010_0000,
        S_DECIDE = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    // Sequencer and item
    t_state      r_state, n_state;
    t_in_word    r_item, n_item;

    // Configuration registers
    logic [15:0]           r_run_sec, n_run_sec;
    logic [SLOTS_BITS-1:0] r_start_min, n_start_min;
    logic [2:0]            r_start_cnt, n_start_cnt;
    logic [6:0]            r_day_mask, n_day_mask;
    logic [15:0]           r_dry_lvl, n_dry_lvl;
    logic [15:0]           r_wet_lvl, n_wet_lvl;
    logic [6:0]            r_dry_thr, n_dry_thr;
    logic [2:0]            r_flags, n_flags;

    // Controller state
    logic        r_valve, n_valve;
    logic [31:0] r_sot, n_sot;
    logic [16:0] r_rl, n_rl;
    logic [31:0] r_last, n_last;
    logic        r_is_dry, n_is_dry;
    logic [6:0]  r_pct, n_pct;
    logic [16:0] r_left, n_left;

    // Working registers
    logic             r_sw, n_sw;
    logic [32:0]      r_elapsed, n_elapsed;
    logic             r_expired, n_expired;
    logic [REM_W-1:0] r_rem, n_rem;
    logic [6:0]       r_quo, n_quo;
    logic [2:0]       r_bit, n_bit;

    // Output register
    t_out_word r_out, n_out;
    logic      r_out_valid, n_out_valid;

    // Shared subtractor
    logic [ALU_W-1:0] alu_a, alu_b;
    t_sub_res         alu_res;

    itc_sub u_sub (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    // Moisture helpers from configuration and the held sample
    logic             span_ok;
    logic [15:0]      span;
    logic [15:0]      samp_cl;
    logic [REM_W-1:0] rem_init;
    logic [REM_W-1:0] div_b;
    logic [6:0]       pct_new;

    // Schedule helpers
    logic [10:0] mod_now;
    logic [2:0]  slot_cnt;
    logic        slot_hit;
    logic [7:0]  day_bits;
    logic        start_due;
    logic [17:0] add_sum;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    always_comb begin
        span_ok  = (r_dry_lvl > r_wet_lvl);
        span     = r_dry_lvl - r_wet_lvl;
        // Clamp the sample into the wet..dry window
        samp_cl  = r_item.moisture_sample;
        if (samp_cl > r_dry_lvl) begin
            samp_cl = r_dry_lvl;
        end
        if (samp_cl < r_wet_lvl) begin
            samp_cl = r_wet_lvl;
        end
        // Ceiling division: bias the dividend by span - 1
        rem_init = REM_W'(samp_cl - r_wet_lvl) * REM_W'(PCT_FULL)
                 + REM_W'(span) - REM_W'(1);
        div_b    = REM_W'(span) << r_bit;
        pct_new  = span_ok ? (PCT_FULL - r_quo) : 7'd0;
    end

    always_comb begin
        mod_now  = 11'(r_item.hour) * SEC_PER_MIN + 11'(r_item.minute);
        slot_cnt = (r_start_cnt > SLOTS_MAX) ? SLOTS_MAX : r_start_cnt;
        slot_hit = 1'b0;
        for (int i = 0; i < START_SLOTS; i++) begin
            if ((3'(i) < slot_cnt) &&
                (r_start_min[i*SLOT_W +: SLOT_W] == mod_now)) begin
                slot_hit = 1'b1;
            end
        end
        day_bits  = {1'b0, r_day_mask};
        // Weekday seven lands on the padding bit and never runs
        start_due = day_bits[r_item.weekday] && slot_hit &&
                    !r_elapsed[32] && (r_elapsed[31:0] > START_GAP);
        add_sum   = 18'(r_rl) + 18'(r_item.extra_seconds);
    end

    // Steer the subtractor by sequencer step
    always_comb begin
        case (r_state)
            S_ELAP: begin
                alu_a = ALU_W'(r_item.now_seconds);
                alu_b = ALU_W'(r_sot);
            end
            S_LEFT: begin
                alu_a = ALU_W'(r_rl);
                alu_b = {{(ALU_W-33){r_elapsed[32]}}, r_elapsed};
            end
            S_DIV: begin
                alu_a = ALU_W'(r_rem);
                alu_b = ALU_W'(div_b);
            end
            default: begin
                alu_a = '0;
                alu_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_run_sec   = r_run_sec;
        n_start_min = r_start_min;
        n_start_cnt = r_start_cnt;
        n_day_mask  = r_day_mask;
        n_dry_lvl   = r_dry_lvl;
        n_wet_lvl   = r_wet_lvl;
        n_dry_thr   = r_dry_thr;
        n_flags     = r_flags;
        n_valve     = r_valve;
        n_sot       = r_sot;
        n_rl        = r_rl;
        n_last      = r_last;
        n_is_dry    = r_is_dry;
        n_pct       = r_pct;
        n_left      = r_left;
        n_sw        = r_sw;
        n_elapsed   = r_elapsed;
        n_expired   = r_expired;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_bit       = r_bit;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        // Drop the result once the consumer takes it
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        // Register writes, idle only
        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_RUN_SECONDS:   n_run_sec   = i_cfg_data[15:0];
                CFG_START_MINUTES: n_start_min = i_cfg_data[SLOTS_BITS-1:0];
                CFG_START_COUNT:   n_start_cnt = i_cfg_data[2:0];
                CFG_DAY_MASK:      n_day_mask  = i_cfg_data[6:0];
                CFG_DRY_LEVEL:     n_dry_lvl   = i_cfg_data[15:0];
                CFG_WET_LEVEL:     n_wet_lvl   = i_cfg_data[15:0];
                CFG_DRY_THRESHOLD: n_dry_thr   = i_cfg_data[6:0];
                CFG_CONTROL_FLAGS: n_flags     = i_cfg_data[2:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_word;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_sw  = 1'b0;
                n_rem = rem_init;
                n_quo = '0;
                n_bit = DIV_TOP;
                case (r_item.func)
                    FUNC_TICK: begin
                        if (r_item.now_seconds == r_last) begin
                            // Repeated second: report held values
                            n_state = S_OUT;
                        end else begin
                            n_last  = r_item.now_seconds;
                            n_state = S_ELAP;
                        end
                    end
                    FUNC_ON: begin
                        n_rl = 17'(r_run_sec);
                        if (!r_valve) begin
                            n_valve = 1'b1;
                            n_sot   = r_item.now_seconds;
                            n_sw    = 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    FUNC_OFF: begin
                        n_rl = '0;
                        if (r_valve) begin
                            n_valve = 1'b0;
                            n_sw    = 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    FUNC_ADD: begin
                        n_rl = (add_sum > 18'(MAX_LEFT)) ? MAX_LEFT : add_sum[16:0];
                        if (!r_valve) begin
                            n_valve = 1'b1;
                            n_sot   = r_item.now_seconds;
                            n_sw    = 1'b1;
                        end
                        n_state = S_ELAP;
                    end
                    default: n_state = S_OUT;
                endcase
            end
            S_ELAP: begin
                n_elapsed = alu_res.diff[32:0];
                n_state   = S_LEFT;
            end
            S_LEFT: begin
                // Left <= 0 means the run has expired
                n_expired = alu_res.neg || alu_res.zero;
                if (!r_valve || alu_res.neg) begin
                    n_left = '0;
                end else if (alu_res.diff[33:17] != '0) begin
                    n_left = MAX_LEFT;
                end else begin
                    n_left = alu_res.diff[16:0];
                end
                if (r_item.func != FUNC_TICK) begin
                    n_state = S_OUT;
                end else if (!r_flags[FLAG_SENSE]) begin
                    n_state = S_DECIDE;
                end else if (span_ok) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_MEAS;
                end
            end
            S_DIV: begin
                // One restoring quotient bit per cycle, top bit first
                if (!alu_res.neg) begin
                    n_rem        = alu_res.diff[REM_W-1:0];
                    n_quo[r_bit] = 1'b1;
                end
                if (r_bit == '0) begin
                    n_state = S_MEAS;
                end else begin
                    n_bit = r_bit - 3'd1;
                end
            end
            S_MEAS: begin
                n_pct    = pct_new;
                n_is_dry = (pct_new < r_dry_thr);
                n_state  = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_run_sec != '0) begin
                    if (r_valve && r_expired) begin
                        n_valve = 1'b0;
                        n_rl    = '0;
                        n_sw    = 1'b1;
                    end else if (r_flags[FLAG_OVERRIDE]) begin
                        n_sw = 1'b0;
                    end else if (r_valve && !r_is_dry) begin
                        n_valve = 1'b0;
                        n_rl    = '0;
                        n_sw    = 1'b1;
                    end else if (!r_valve && start_due && r_is_dry &&
                                 r_flags[FLAG_ACTIVE]) begin
                        n_rl    = 17'(r_run_sec);
                        n_valve = 1'b1;
                        n_sot   = r_item.now_seconds;
                        n_sw    = 1'b1;
                    end
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold here until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out.relay_on         = r_valve;
                    n_out.switched         = r_sw;
                    n_out.seconds_left     = r_left;
                    n_out.soil_dry         = r_is_dry;
                    n_out.moisture_percent = r_pct;
                    n_out_valid            = 1'b1;
                    n_state                = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_run_sec   <= '0;
            r_start_min <= '0;
            r_start_cnt <= '0;
            r_day_mask  <= 7'h7F;
            r_dry_lvl   <= '0;
            r_wet_lvl   <= '0;
            r_dry_thr   <= '0;
            r_flags     <= '0;
            r_valve     <= 1'b0;
            r_sot       <= '0;
            r_rl        <= '0;
            r_last      <= '0;
            r_is_dry    <= 1'b1;
            r_pct       <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_run_sec   <= n_run_sec;
            r_start_min <= n_start_min;
            r_start_cnt <= n_start_cnt;
            r_day_mask  <= n_day_mask;
            r_dry_lvl   <= n_dry_lvl;
            r_wet_lvl   <= n_wet_lvl;
            r_dry_thr   <= n_dry_thr;
            r_flags     <= n_flags;
            r_valve     <= n_valve;
            r_sot       <= n_sot;
            r_rl        <= n_rl;
            r_last      <= n_last;
            r_is_dry    <= n_is_dry;
            r_pct       <= n_pct;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_sw      <= n_sw;
        r_elapsed <= n_elapsed;
        r_expired <= n_expired;
        r_rem     <= n_rem;
        r_quo     <= n_quo;
        r_bit     <= n_bit;
        r_out     <= n_out;
    end

    // A closed valve never keeps a run length
    a_off_no_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_valve |-> (r_rl == '0))
        else $error("valve off with nonzero run length");

    // An accepted word blocks the next one
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while busy");

    // The ceiling quotient never exceeds full scale
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MEAS) && span_ok) |-> (r_quo <= PCT_FULL))
        else $error("moisture quotient above full scale");

    // A result appears only from the load step
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("result loaded outside load step");

endmodule

// ===== rtl/itc_sub.sv =====
`timescale 1ns / 1ps

module itc_sub
    import itc_pkg::*;
(
    input  logic [ALU_W-1:0] i_a,
    input  logic [ALU_W-1:0] i_b,
    output t_sub_res         o_res
);

    logic [ALU_W-1:0] diff;

    // Two's complement difference, sign and zero for compares
    assign diff       = i_a - i_b;
    assign o_res.diff = diff;
    assign o_res.neg  = diff[ALU_W-1];
    assign o_res.zero = (diff == '0);

endmodule

// ===== sim/irrigation_timer_controller_unit_tb.sv =====
`timescale 1ns / 1ps

module irrigation_timer_controller_unit_tb;
    import itc_pkg::*;

    localparam int          SLOTS        = 4;
    localparam int          SETTLE       = 16;      // idle cycles after the last result
    localparam int          HOLD_CYCLES  = 400;     // long output hold-off
    localparam int          PHASE_WORDS  = 160;
    localparam int          REPORT_CAP   = 100;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    // Clock, reset and block ports; every input starts at a known value
    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_word         i_in_word   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_word        o_out_word;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [2:0]       i_cfg_index = CFG_RUN_SECONDS;
    logic [CFG_W-1:0] i_cfg_data  = '0;

    irrigation_timer_controller_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Shadow of the configuration registers, reset values
    logic [15:0]      cfg_run    = '0;
    logic [CFG_W-1:0] cfg_starts = '0;
    logic [2:0]       cfg_count  = '0;
    logic [6:0]       cfg_days   = 7'h7F;
    logic [15:0]      cfg_dry    = '0;
    logic [15:0]      cfg_wet    = '0;
    logic [6:0]       cfg_thresh = '0;
    logic [2:0]       cfg_flags  = '0;

    // Controller state as it should be after every accepted word
    logic        valve_q  = 1'b0;
    logic [31:0] on_time  = '0;
    logic [16:0] run_len  = '0;
    logic [31:0] last_sec = '0;
    logic        dry_q    = 1'b1;
    logic [6:0]  pct_q    = '0;
    logic [16:0] left_q   = '0;

    t_in_word    pending_words[$];      // words waiting to be offered
    t_out_word   expected_status[$];    // status words the block still owes

    t_idle_mode  idle_mode   = IDLE_NONE;
    logic [31:0] clock_now   = '0;      // running epoch second for random ticks
    int          errors      = 0;
    int          words_sent  = 0;
    int          results_seen = 0;
    int          switch_count = 0;
    int          settings_used = 0;
    int          hold_req    = 0;
    int          hold_ack    = 0;
    int          hold_left   = 0;
    int unsigned cycle_count = 0;

    // Seconds left in the current run at time now, clamped to the 17-bit range
    function automatic logic [16:0] left_at(logic [31:0] now);
        longint rem, now_l, on_l;
        if (!valve_q) return '0;
        now_l = now;
        on_l  = on_time;
        rem   = run_len;
        rem   = rem - (now_l - on_l);
        if (rem < 0) return '0;
        if (rem > 131071) return MAX_LEFT;
        return rem[16:0];
    endfunction

    // Moisture percent from the current sample, then the dry classification
    function automatic void grade_soil(logic [15:0] sample);
        int unsigned s, span, num, pct;
        if (cfg_dry <= cfg_wet) begin
            pct = 0;
        end else begin
            s = sample;
            if (s > cfg_dry) s = cfg_dry;
            if (s < cfg_wet) s = cfg_wet;
            span = cfg_dry - cfg_wet;
            num  = (s - cfg_wet) * 100;
            pct  = 100 - (num + span - 1) / span;
        end
        pct_q = pct[6:0];
        dry_q = (pct < cfg_thresh);
    endfunction

    // A start is due on an enabled weekday at a slot minute, once a minute has passed
    function automatic logic start_due(t_in_word w);
        int unsigned slots_used, day_minute;
        longint      since_on, now_l, on_l;
        if (w.weekday > 6 || !cfg_days[w.weekday]) return 1'b0;
        slots_used = (cfg_count > SLOTS) ? SLOTS : cfg_count;
        day_minute = w.hour * 60 + w.minute;
        now_l      = w.now_seconds;
        on_l       = on_time;
        since_on   = now_l - on_l;
        for (int i = 0; i < slots_used; i++) begin
            if (cfg_starts[SLOT_W*i +: SLOT_W] == day_minute && since_on > 60) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Tick handling; returns 1 when the relay changes
    function automatic logic valve_tick(t_in_word w);
        longint now_l, end_l;
        if (w.now_seconds == last_sec) return 1'b0;
        last_sec = w.now_seconds;
        left_q   = left_at(w.now_seconds);
        if (cfg_flags[FLAG_SENSE]) grade_soil(w.moisture_sample);
        if (cfg_run == 0) return 1'b0;
        now_l = w.now_seconds;
        end_l = on_time;
        end_l = end_l + run_len;
        if (valve_q && now_l >= end_l) begin
            valve_q = 1'b0;
            run_len = '0;
            return 1'b1;
        end
        if (cfg_flags[FLAG_OVERRIDE]) return 1'b0;
        if (valve_q && !dry_q) begin
            valve_q = 1'b0;
            run_len = '0;
            return 1'b1;
        end
        if (!valve_q && start_due(w)) begin
            if (!dry_q || !cfg_flags[FLAG_ACTIVE]) return 1'b0;
            run_len = cfg_run;
            valve_q = 1'b1;
            on_time = w.now_seconds;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the controller by one input word and build the status word it owes
    function automatic t_out_word advance_valve(t_in_word w);
        t_out_word   r;
        logic        flip;
        int unsigned sum;
        flip = 1'b0;
        case (w.func)
            FUNC_TICK: flip = valve_tick(w);
            FUNC_ON: begin
                run_len = cfg_run;
                if (!valve_q) begin
                    valve_q = 1'b1;
                    on_time = w.now_seconds;
                    flip    = 1'b1;
                end
            end
            FUNC_OFF: begin
                run_len = '0;
                if (valve_q) begin
                    valve_q = 1'b0;
                    flip    = 1'b1;
                end
            end
            default: begin
                // add run time: saturate the length, start if off, refresh seconds left
                sum     = run_len + w.extra_seconds;
                run_len = (sum > MAX_LEFT) ? MAX_LEFT : sum[16:0];
                if (!valve_q) begin
                    valve_q = 1'b1;
                    on_time = w.now_seconds;
                    flip    = 1'b1;
                end
                left_q = left_at(w.now_seconds);
            end
        endcase
        r.relay_on         = valve_q;
        r.switched         = flip;
        r.seconds_left     = left_q;
        r.soil_dry         = dry_q;
        r.moisture_percent = pct_q;
        return r;
    endfunction

    function automatic t_in_word valve_word(t_func f, logic [31:0] now, logic [4:0] hh,
                                            logic [5:0] mm, logic [2:0] wd,
                                            logic [15:0] smp, logic [15:0] add);
        t_in_word w;
        w.func            = f;
        w.now_seconds     = now;
        w.hour            = hh;
        w.minute          = mm;
        w.weekday         = wd;
        w.moisture_sample = smp;
        w.extra_seconds   = add;
        return w;
    endfunction

    // Append one word to the queue the driver offers from
    function automatic void queue_item(t_in_word w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    function automatic logic [CFG_W-1:0] random_starts();
        logic [CFG_W-1:0] v;
        for (int i = 0; i < SLOTS; i++) v[SLOT_W*i +: SLOT_W] = 11'($urandom_range(1439));
        return v;
    endfunction

    // Mostly a clock that runs forward a few seconds at a time, with schedule minutes
    // picked from any of the slots; the rest is repeats, big jumps and odd times.
    function automatic t_in_word random_item();
        t_in_word    w;
        int unsigned r, slot_idx, slot;
        r = $urandom_range(99);
        if (r < 8) begin
            // hold the second: a repeated tick
        end else if (r < 85) begin
            clock_now = clock_now + $urandom_range(5, 1);
        end else if (r < 95) begin
            clock_now = clock_now + $urandom_range(200, 30);
        end else begin
            clock_now = $urandom;
        end
        r = $urandom_range(99);
        if (r < 70)      w.func = FUNC_TICK;
        else if (r < 80) w.func = FUNC_ON;
        else if (r < 88) w.func = FUNC_OFF;
        else             w.func = FUNC_ADD;
        w.now_seconds = clock_now;
        r = $urandom_range(99);
        if (r < 55) begin
            slot_idx = $urandom_range(SLOTS - 1);
            slot     = cfg_starts[SLOT_W*slot_idx +: SLOT_W];
            w.hour   = 5'(slot / 60);
            w.minute = 6'(slot % 60);
        end else if (r < 85) begin
            w.hour   = 5'($urandom_range(23));
            w.minute = 6'($urandom_range(59));
        end else begin
            w.hour   = 5'($urandom_range(31));
            w.minute = 6'($urandom_range(63));
        end
        w.weekday = ($urandom_range(9) == 0) ? 3'd7 : 3'($urandom_range(6));
        r = $urandom_range(99);
        if (r < 45 && cfg_dry > cfg_wet) w.moisture_sample = 16'($urandom_range(cfg_dry, cfg_wet));
        else if (r < 55)                 w.moisture_sample = 16'h0000;
        else if (r < 65)                 w.moisture_sample = 16'hFFFF;
        else                             w.moisture_sample = 16'($urandom);
        w.extra_seconds = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(300));
        return w;
    endfunction

    function automatic logic roll_idle(logic side_active);
        int pct;
        pct = (idle_mode == IDLE_BOTH) ? 24 : 55;
        return side_active && ($urandom_range(99) < pct);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Driver: offer the next pending word, hold it until taken, predict on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_status.insert(expected_status.size(), advance_valve(i_in_word));
                words_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 &&
                    !roll_idle(idle_mode == IDLE_SEND || idle_mode == IDLE_BOTH)) begin
                    i_in_valid <= 1'b1;
                    i_in_word  <= pending_words.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every accepted status word with the oldest one owed
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_status.size() == 0) begin
                    errors++;
                    $display("%0t: status word with none owed, got %h", $time, o_out_word);
                end else begin
                    want = expected_status.pop_front();
                    check_field("relay_on", want.relay_on, o_out_word.relay_on);
                    check_field("switched", want.switched, o_out_word.switched);
                    check_field("seconds_left", want.seconds_left, o_out_word.seconds_left);
                    check_field("soil_dry", want.soil_dry, o_out_word.soil_dry);
                    check_field("moisture_percent", want.moisture_percent,
                                o_out_word.moisture_percent);
                    if (want.switched) switch_count++;
                end
            end
            i_out_ready <= (hold_left == 0) &&
                           !roll_idle(idle_mode == IDLE_RECV || idle_mode == IDLE_BOTH);
        end
    end

    // Long hold-off on the output side: count it down here, on request
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("irrigation_timer_controller_unit_tb: FAIL");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_RUN_SECONDS:   cfg_run    = val[15:0];
            CFG_START_MINUTES: cfg_starts = val;
            CFG_START_COUNT:   cfg_count  = val[2:0];
            CFG_DAY_MASK:      cfg_days   = val[6:0];
            CFG_DRY_LEVEL:     cfg_dry    = val[15:0];
            CFG_WET_LEVEL:     cfg_wet    = val[15:0];
            CFG_DRY_THRESHOLD: cfg_thresh = val[6:0];
            default:           cfg_flags  = val[2:0];
        endcase
    endtask

    task automatic load_settings(input logic [15:0] run, input logic [CFG_W-1:0] starts,
                                 input logic [2:0] count, input logic [6:0] days,
                                 input logic [15:0] dry, input logic [15:0] wet,
                                 input logic [6:0] thresh, input logic [2:0] flags);
        write_reg(CFG_RUN_SECONDS, run);
        write_reg(CFG_START_MINUTES, starts);
        write_reg(CFG_START_COUNT, count);
        write_reg(CFG_DAY_MASK, days);
        write_reg(CFG_DRY_LEVEL, dry);
        write_reg(CFG_WET_LEVEL, wet);
        write_reg(CFG_DRY_THRESHOLD, thresh);
        write_reg(CFG_CONTROL_FLAGS, flags);
        settings_used++;
    endtask

    // Block until every word is taken and answered, then let the sequencer settle
    task automatic wait_drained();
        while (pending_words.size() != 0 || i_in_valid || expected_status.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        logic [2:0] sense_on;
        sense_on = 3'b0;
        sense_on[FLAG_ACTIVE] = 1'b1;
        sense_on[FLAG_SENSE]  = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: schedule 06:00, 06:01, 23:59, 00:00; dry 40000, wet 10000, threshold 50
        load_settings(16'd30, {11'd0, 11'd1439, 11'd361, 11'd360}, 3'd4, 7'h7F,
                      16'd40000, 16'd10000, 7'd50, sense_on);
        // repeated second at zero, then a scheduled start on dry soil
        queue_item(valve_word(FUNC_TICK, 32'd0, 5'd6, 6'd0, 3'd1, 16'd40000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd100, 5'd6, 6'd0, 3'd1, 16'd40000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd100, 5'd6, 6'd0, 3'd1, 16'd40000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd110, 5'd6, 6'd0, 3'd1, 16'hFFFF, 16'd0));
        // wet soil stops the run; samples below wet clamp to 100 percent
        queue_item(valve_word(FUNC_TICK, 32'd115, 5'd6, 6'd0, 3'd1, 16'd10000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd140, 5'd6, 6'd1, 3'd1, 16'd0, 16'd0));
        // percent right at the threshold, then one step drier: start fires
        queue_item(valve_word(FUNC_TICK, 32'd200, 5'd6, 6'd1, 3'd1, 16'd25000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd201, 5'd6, 6'd1, 3'd1, 16'd25001, 16'd0));
        // run expires
        queue_item(valve_word(FUNC_TICK, 32'd231, 5'd6, 6'd1, 3'd1, 16'd40000, 16'd0));
        // manual on twice, add time up to saturation
        queue_item(valve_word(FUNC_ON, 32'd240, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_ON, 32'd245, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_ADD, 32'd250, 5'd0, 6'd0, 3'd0, 16'd0, 16'hFFFF));
        queue_item(valve_word(FUNC_ADD, 32'd251, 5'd0, 6'd0, 3'd0, 16'd0, 16'hFFFF));
        queue_item(valve_word(FUNC_TICK, 32'd252, 5'd0, 6'd0, 3'd7, 16'd40000, 16'd0));
        // manual off twice, add of zero from off at the top second, then expiry
        queue_item(valve_word(FUNC_OFF, 32'd260, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_OFF, 32'd261, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_ADD, 32'hFFFF_FFFF, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'hFFFF_FFFF, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        // slot match with time behind the switch-on second; out-of-range clock fields
        queue_item(valve_word(FUNC_TICK, 32'hFFFF_FFFE, 5'd23, 6'd59, 3'd6, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd4096, 5'd31, 6'd63, 3'd0, 16'hFFFF, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd5000, 5'd0, 6'd0, 3'd7, 16'd40000, 16'd0));
        // move the switch-on second back to zero, then a midnight start
        queue_item(valve_word(FUNC_ON, 32'd0, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_OFF, 32'd0, 5'd0, 6'd0, 3'd0, 16'd0, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd5002, 5'd0, 6'd0, 3'd0, 16'd40000, 16'd0));
        queue_item(valve_word(FUNC_TICK, 32'd5003, 5'd0, 6'd0, 3'd0, 16'd39999, 16'd0));
        wait_drained();

        clock_now = 32'd6000;
        for (int k = 1; k <= 8; k++) begin
            case (k)
                // everything at its lowest: automatic control off, manual words only act
                1: load_settings('0, '0, '0, '0, '0, '0, '0, '0);
                // everything at its highest: count above the slot limit, dry equals wet
                2: load_settings(16'hFFFF, '1, 3'd7, 7'h7F, 16'hFFFF, 16'hFFFF, 7'h7F, 3'b111);
                // realistic schedule with short runs
                3: load_settings(16'($urandom_range(120, 20)), random_starts(), 3'd4,
                                 7'($urandom_range(127, 1)), 16'd50000, 16'd8000,
                                 7'($urandom_range(90, 30)), sense_on);
                // schedule override: only expiry stops a run
                4: load_settings(16'($urandom_range(90, 10)), random_starts(), 3'd4, 7'h7F,
                                 16'd50000, 16'd8000, 7'd60, 3'b111);
                // sensing off: held percent and dry flag stay put
                5: load_settings(16'($urandom_range(90, 10)), random_starts(),
                                 3'($urandom_range(4, 1)), 7'h7F, 16'd50000, 16'd8000, 7'd60,
                                 3'b001);
                // dry level below wet: percent always zero
                6: load_settings(16'($urandom_range(90, 10)), random_starts(), 3'd4, 7'h7F,
                                 16'd1000, 16'd2000, 7'd1, sense_on);
                7: load_settings(16'($urandom), 44'({$urandom, $urandom}), 3'($urandom),
                                 7'($urandom), 16'($urandom), 16'($urandom), 7'($urandom),
                                 3'($urandom));
                default: load_settings(16'($urandom_range(120, 20)), random_starts(), 3'd4,
                                       7'h7F, 16'd50000, 16'd8000, 7'd70, sense_on);
            endcase
            idle_mode = t_idle_mode'(k % 4);
            if (k == 8) begin
                // hold the output side off while words keep coming, so the input stalls
                idle_mode = IDLE_NONE;
                @(negedge i_clk);
                hold_req++;
            end
            for (int n = 0; n < PHASE_WORDS; n++) queue_item(random_item());
            wait_drained();
        end

        if (errors > REPORT_CAP) $display("%0d further mismatches not shown", errors - REPORT_CAP);
        $display("Sent %0d words under %0d register settings and four idling mixes,",
                 words_sent, settings_used);
        $display("with one long output hold-off; %0d status words checked, %0d relay switches.",
                 results_seen, switch_count);
        if (errors == 0 && expected_status.size() == 0) begin
            $display("irrigation_timer_controller_unit_tb: PASS");
        end else begin
            $display("irrigation_timer_controller_unit_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/itc_pkg.sv
rtl/itc_sub.sv
rtl/irrigation_timer_controller_unit.sv
sim/irrigation_timer_controller_unit_tb.sv
